/* rtl/raw_bytes_to_double_decoder_core_assert.svh */
// Assertion macros for the raw byte to double decoder
`ifndef RAW_BYTES_TO_DOUBLE_DECODER_CORE_ASSERT_SVH
`define RAW_BYTES_TO_DOUBLE_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* rtl/rbd_pkg.sv */
// Shared types and constants for the raw byte to double decoder
`timescale 1ns / 1ps
package rbd_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 4;
  localparam int unsigned PosW  = 6;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_PASS   = 2'd2
  } kind_e;

  function automatic logic [PosW-1:0] top_bit(input logic [DataW-1:0] v);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 0; i < DataW; i++) begin
      if (v[i]) p = PosW'(i);
    end
    return p;
  endfunction
endpackage

/* rtl/rbd_norm.sv */
// Normalise/round ints, widen singles, pass doubles to binary64 in three stages
`timescale 1ns / 1ps
module rbd_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       vld_i,
  input  logic [rbd_pkg::DataW-1:0]  mag_i,
  input  logic                       neg_i,
  input  rbd_pkg::kind_e             kind_i,
  input  logic [rbd_pkg::DataW-1:0]  raw_i,
  output logic                       vld_o,
  output logic [rbd_pkg::DataW-1:0]  bits_o
);
  import rbd_pkg::*;
  `include "raw_bytes_to_double_decoder_core_assert.svh"

  logic             v1_q, v2_q, v3_q;
  logic [DataW-1:0] mag1_q, raw1_q, sh2_q, raw2_q, bits3_q;
  logic             neg1_q, neg2_q, nz1_q, nz2_q;
  kind_e            kind1_q, kind2_q;
  logic [PosW-1:0]  p1_q, p2_q;
  logic [PosW-1:0]  p1_d;
  logic [DataW-1:0] sh2_d, bits3_d;

  assign p1_d = top_bit(mag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag1_q  <= mag_i;
      raw1_q  <= raw_i;
      neg1_q  <= neg_i;
      kind1_q <= kind_i;
      p1_q    <= p1_d;
      nz1_q   <= |mag_i;
      sh2_q   <= sh2_d;
      raw2_q  <= raw1_q;
      neg2_q  <= neg1_q;
      kind2_q <= kind1_q;
      p2_q    <= p1_q;
      nz2_q   <= nz1_q;
      bits3_q <= bits3_d;
    end
  end

  // left-justify so the leading one sits at bit 63
  assign sh2_d = mag1_q << (PosW'(DataW - 1) - p1_q);

  logic [52:0]  kept;
  logic [53:0]  rnd;
  logic         lsb, grd, stk;
  logic [10:0]  ex;
  logic [51:0]  frac;
  logic [31:0]  f;
  logic [22:0]  m;
  logic [7:0]   e;

  always_comb begin
    kept = sh2_q[63:11];
    lsb  = sh2_q[11];
    grd  = sh2_q[10];
    stk  = |sh2_q[9:0];
    rnd  = {1'b0, kept} + 54'((grd && (stk || lsb)) ? 1 : 0);
    ex   = 11'(p2_q) + 11'd1023 + 11'(rnd[53]);
    frac = rnd[53] ? rnd[52:1] : rnd[51:0];
    f    = raw2_q[31:0];
    m    = f[22:0];
    e    = f[30:23];
    case (kind2_q)
      KIND_PASS: bits3_d = raw2_q;
      KIND_SINGLE: begin
        if (e == 8'hff) begin
          bits3_d = {f[31], 11'h7ff, (m == 23'd0) ? 52'd0 : {1'b1, m[21:0], 29'd0}};
        end else if (e == 8'd0) begin
          // sh2 holds the subnormal mantissa left-justified; p2 is its top bit
          bits3_d = (m == 23'd0) ? {f[31], 63'd0}
                  : {f[31], 11'(p2_q) + 11'd874, sh2_q[62:11]};
        end else begin
          bits3_d = {f[31], 11'(e) + 11'd896, m, 29'd0};
        end
      end
      default: bits3_d = nz2_q ? {neg2_q, ex, frac} : '0;
    endcase
  end

  assign vld_o  = v3_q;
  assign bits_o = bits3_q;

  `RBD_ASSERT(a_zero_int, clk_i, rst_ni, (adv_i && v2_q && kind2_q == KIND_INT && !nz2_q) |=> (bits3_q == '0), "zero integer must give +0.0")
  `RBD_ASSERT(a_hold, clk_i, rst_ni, (!adv_i) |=> ($stable(v3_q) && $stable(bits3_q)), "stalled stage moved")
  `RBD_ASSERT(a_pass, clk_i, rst_ni, (adv_i && v2_q && kind2_q == KIND_PASS) |=> (bits3_q == $past(raw2_q)), "double pass-through altered")
endmodule

/* rtl/raw_bytes_to_double_decoder_core.sv */
// Top level: raw little-endian sample bytes to binary64 bits
// Pipeline: four register stages from accepted input to result valid (decode, find top bit,
// shift, round/pack); the last of the four register stages drives the output.
// Throughput: one transaction per cycle; the whole pipe holds on output stall.
// Reset: asynchronous active-low rst_ni clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module raw_bytes_to_double_decoder_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [rbd_pkg::DataW-1:0] raw_bytes_i,
  input  logic [rbd_pkg::CntW-1:0]  byte_count_i,
  input  logic                      float_flag_i,
  input  logic                      signed_flag_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [rbd_pkg::DataW-1:0] double_bits_o
);
  import rbd_pkg::*;
  `include "raw_bytes_to_double_decoder_core_assert.svh"

  logic             adv;
  logic             v0_q;
  logic [DataW-1:0] mag0_q, raw0_q;
  logic             neg0_q;
  kind_e            kind0_q;
  logic [3:0]       cnt;
  logic [DataW-1:0] mask, v, mag_d;
  logic             neg_d, sgn_ok;
  kind_e            kind_d;

  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  always_comb begin
    cnt = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    for (int i = 0; i < 8; i++) mask[8*i +: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
    v      = raw_bytes_i & mask;
    neg_d  = 1'b0;
    mag_d  = v;
    kind_d = KIND_INT;
    sgn_ok = (cnt == 4'd1 && v[7]) || (cnt == 4'd2 && v[15])
          || (cnt == 4'd4 && v[31]) || (cnt == 4'd8 && v[63]);
    if (float_flag_i) begin
      if (cnt == 4'd4) begin
        kind_d = KIND_SINGLE;
        mag_d  = {41'd0, v[22:0]};
      end else if (cnt == 4'd8) begin
        kind_d = KIND_PASS;
      end
    end else if (signed_flag_i && sgn_ok) begin
      neg_d = 1'b1;
      mag_d = '0 - (v | ~mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag0_q  <= mag_d;
      raw0_q  <= v;
      neg0_q  <= neg_d;
      kind0_q <= kind_d;
    end
  end

  rbd_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (v0_q),
    .mag_i  (mag0_q),
    .neg_i  (neg0_q),
    .kind_i (kind0_q),
    .raw_i  (raw0_q),
    .vld_o  (valid_o),
    .bits_o (double_bits_o)
  );

  `RBD_ASSERT(a_stall_link, clk_i, rst_ni, stall_o |-> (valid_o && stall_i), "input stalled without output stall")
  `RBD_ASSERT(a_out_hold, clk_i, rst_ni, (valid_o && stall_i) |=> (valid_o && $stable(double_bits_o)), "stalled result changed")
  `RBD_ASSERT_RST(a_rst_clear, clk_i, !rst_ni |=> !v0_q, "valid not cleared in reset")
endmodule

/* tb/sv/tb_checker.sv */
// Checker: watches both channels, predicts binary64 results and compares them
`timescale 1ns / 1ps
module tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [63:0] raw_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        float_flag_i,
  input  logic        signed_flag_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [63:0] double_bits_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);
  logic [63:0] expected_doubles[$];

  function automatic int msb_pos(input logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  function automatic logic [63:0] int_to_double(input logic [63:0] mag, input logic neg);
    int p;
    int sh;
    logic [64:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [10:0] ex;
    if (mag == 0) return 64'd0;
    p = msb_pos(mag);
    ex = 11'(p + 1023);
    if (p <= 52) begin
      kept = 65'(mag) << (52 - p);
    end else begin
      sh = p - 52;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      kept = 65'(mag >> sh);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      if (kept[53]) begin
        kept = kept >> 1;
        ex = ex + 1;
      end
    end
    return {neg, ex, kept[51:0]};
  endfunction

  function automatic logic [63:0] widen_single(input logic [31:0] f);
    logic [7:0] e;
    logic [51:0] m;
    int p;
    logic [63:0] sh;
    e = f[30:23];
    m = {f[22:0], 29'd0};
    if (e == 8'hFF) begin
      if (f[22:0] == 0) return {f[31], 11'h7FF, 52'd0};
      return {f[31], 11'h7FF, m | (52'd1 << 51)};
    end
    if (e == 0) begin
      if (f[22:0] == 0) return {f[31], 63'd0};
      p = msb_pos({41'd0, f[22:0]});
      sh = {41'd0, f[22:0]} << (52 - p);
      return {f[31], 11'(p + 874), sh[51:0]};
    end
    return {f[31], 11'(e + 896), m};
  endfunction

  function automatic logic [63:0] decode_sample(input logic [63:0] raw, input logic [3:0] cnt_in,
                                                input logic fl_in, input logic sg_in);
    int cnt;
    logic [63:0] mask;
    logic [63:0] v;
    cnt = (cnt_in > 8) ? 8 : int'(cnt_in);
    mask = (cnt == 8) ? '1 : ((64'd1 << (8 * cnt)) - 1);
    v = raw & mask;
    if (fl_in) begin
      if (cnt == 4) return widen_single(v[31:0]);
      if (cnt == 8) return v;
      return int_to_double(v, 1'b0);
    end
    if (sg_in && (cnt == 1 || cnt == 2 || cnt == 4 || cnt == 8) && v[8 * cnt - 1]) begin
      v = v | ~mask;
      return int_to_double(64'd0 - v, 1'b1);
    end
    return int_to_double(v, 1'b0);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
  end

  assign pending_o = expected_doubles.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o)
        expected_doubles.push_back(decode_sample(raw_bytes_i, byte_count_i,
                                                 float_flag_i, signed_flag_i));
      if (valid_o && !stall_i) begin
        results_seen_o++;
        if (expected_doubles.size() == 0)
          report_mismatch("unexpected result", double_bits_o, 64'd0);
        else begin
          if (double_bits_o !== expected_doubles[0])
            report_mismatch("double_bits", double_bits_o, expected_doubles[0]);
          void'(expected_doubles.pop_front());
        end
      end
    end
  end
endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_top;
  localparam int CycleLimit = 400000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        valid_i = 0;
  logic        stall_o;
  logic [63:0] raw_bytes_i = '0;
  logic [3:0]  byte_count_i = 4'd1;
  logic        float_flag_i = 0;
  logic        signed_flag_i = 0;
  logic        valid_o;
  logic        stall_i = 0;
  logic [63:0] double_bits_o;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          cycle_count = 0;
  bit          hold_off = 0;
  int          sent = 0;

  always #5 clk_i = ~clk_i;

  raw_bytes_to_double_decoder_core u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .raw_bytes_i, .byte_count_i,
    .float_flag_i, .signed_flag_i, .valid_o, .stall_i, .double_bits_o
  );

  tb_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o, .raw_bytes_i, .byte_count_i,
    .float_flag_i, .signed_flag_i, .valid_o, .stall_i, .double_bits_o,
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern, long hold-off on request, quiet stretches
  always @(negedge clk_i) begin
    if (hold_off) stall_i <= 1'b1;
    else if (cycle_count % 600 < 150) stall_i <= 1'b0;
    else stall_i <= ($urandom_range(0, 3) == 0);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_sample(input logic [63:0] raw, input logic [3:0] cnt,
                             input logic fl, input logic sg);
    raw_bytes_i   <= raw;
    byte_count_i  <= cnt;
    float_flag_i  <= fl;
    signed_flag_i <= sg;
    valid_i       <= 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic pause_sender(input int n);
    valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_random_sample();
    logic [63:0] raw;
    logic [3:0]  cnt;
    logic [31:0] f;
    raw = rand64();
    case ($urandom_range(0, 9))
      0: raw = raw >> $urandom_range(0, 63);
      1: raw = {raw[63:54], 54'h0} | (64'd1 << $urandom_range(0, 63));
      2: raw = raw | (64'h1F << 49);
      default: ;
    endcase
    cnt = 4'($urandom_range(1, 8));
    if ($urandom_range(0, 19) == 0) cnt = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) begin
      cnt = 4'd4;
      f = raw[31:0];
      case ($urandom_range(0, 3))
        0: f[30:23] = 8'hFF;
        1: f[30:23] = 8'h00;
        default: ;
      endcase
      raw[31:0] = f;
      send_sample(raw, cnt, 1'b1, 1'($urandom_range(0, 1)));
    end else begin
      send_sample(raw, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(64'h0, 4'd1, 1'b0, 1'b0);
    send_sample('1, 4'd8, 1'b0, 1'b0);
    send_sample('1, 4'd8, 1'b0, 1'b1);
    send_sample(64'h8000_0000_0000_0000, 4'd8, 1'b0, 1'b1);
    send_sample(64'h80, 4'd1, 1'b0, 1'b1);
    send_sample(64'hFF, 4'd1, 1'b0, 1'b1);
    send_sample(64'h8000, 4'd2, 1'b0, 1'b1);
    send_sample(64'h8000_0000, 4'd4, 1'b0, 1'b1);
    send_sample(64'hFF_FFFF, 4'd3, 1'b0, 1'b1);
    send_sample(64'h0020_0000_0000_0001, 4'd7, 1'b0, 1'b1);
    send_sample(64'h0060_0000_0000_0000, 4'd8, 1'b0, 1'b0);
    send_sample(64'h7FC0_0001, 4'd4, 1'b1, 1'b0);
    send_sample(64'hFF80_0000, 4'd4, 1'b1, 1'b1);
    send_sample(64'h8000_0001, 4'd4, 1'b1, 1'b0);
    send_sample(64'h007F_FFFF, 4'd4, 1'b1, 1'b0);
    send_sample(64'h8000_0000, 4'd4, 1'b1, 1'b0);
    send_sample(64'h3F80_0000, 4'd4, 1'b1, 1'b0);
    send_sample(64'h7FF8_0000_0000_0001, 4'd8, 1'b1, 1'b0);
    send_sample('1, 4'd6, 1'b1, 1'b1);
    send_sample('1, 4'd0, 1'b0, 1'b1);
    send_sample('1, 4'd15, 1'b0, 1'b1);
    send_sample('1, 4'd9, 1'b1, 1'b0);

    // wait out every result before going on
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    // long receiver hold-off with the sender still offering
    hold_off = 1;
    fork
      repeat (60) @(negedge clk_i);
      repeat (20) send_random_sample();
    join_any
    @(negedge clk_i);
    hold_off = 0;
    wait fork;

    while (sent < 820) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_random_sample();
      if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 8));
    end
    valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d samples covering all byte counts, float and signed modes;", sent);
    $display("checked %0d results including NaN, subnormal and rounding cases.", results_seen);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
